>>> src/dwc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared types, constants and calendar helpers of the date window condition.
// ----------------------------------------------------------------------------
package dwc_pkg;

	localparam int unsigned YEAR_W  = 12;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned YDAY_W  = 9;
	localparam int unsigned SEL_W   = 6;
	localparam int unsigned CNT_W   = 9;
	localparam int unsigned CFG_W   = 9;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned DIST_W  = 10;
	localparam int unsigned WDAY_W  = 11;

	// inverse of 25 modulo 2**12 and the largest image of a multiple of 25
	localparam logic [YEAR_W-1:0] DIV25_INV = 12'd3113;
	localparam logic [YEAR_W-1:0] DIV25_MAX = 12'd163;

	localparam logic [SEL_W-1:0] SEL_PERIOD   = 6'd0;
	localparam logic [SEL_W-1:0] SEL_LAST_DAY = 6'd32;

	typedef enum logic [IDX_W-1:0] {
		REG_START_DAY        = 3'd0,
		REG_START_MONTH      = 3'd1,
		REG_END_DAY          = 3'd2,
		REG_END_MONTH        = 3'd3,
		REG_PERIOD_DAYS      = 3'd4,
		REG_RUN_DAYS         = 3'd5,
		REG_MONTH_DAY_SELECT = 3'd6
	} dwc_reg_t;

	typedef struct packed {
		logic use_rem;
		logic direct_met;
	} dwc_side_t;

	// days before the first of month m in a common year, counted from January 1, for m of 3 and up
	function automatic logic [WDAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [WDAY_W-1:0] ofs;
		case (m)
			4'd3:    ofs = 11'd59;
			4'd4:    ofs = 11'd90;
			4'd5:    ofs = 11'd120;
			4'd6:    ofs = 11'd151;
			4'd7:    ofs = 11'd181;
			4'd8:    ofs = 11'd212;
			4'd9:    ofs = 11'd243;
			4'd10:   ofs = 11'd273;
			4'd11:   ofs = 11'd304;
			4'd12:   ofs = 11'd334;
			4'd13:   ofs = 11'd365;
			4'd14:   ofs = 11'd396;
			4'd15:   ofs = 11'd426;
			default: ofs = 11'd0;
		endcase
		return ofs;
	endfunction

	// zero-based day of the year of a window edge; day zero of month 0 or 1 gives -1
	function automatic logic signed [WDAY_W-1:0] win_day(
		input logic [MONTH_W-1:0] m,
		input logic [DAY_W-1:0]   d,
		input logic               leap
	);
		logic signed [WDAY_W-1:0] dd;
		logic signed [WDAY_W-1:0] res;
		dd = $signed({{(WDAY_W-DAY_W){1'b0}}, d});
		if (m == 4'd2) begin
			res = dd + 11'sd30;
		end else if (m < 4'd3) begin
			res = dd - 11'sd1;
		end else begin
			res = dd - 11'sd1 + $signed(month_offset(m))
				+ $signed({{(WDAY_W-1){1'b0}}, leap});
		end
		return res;
	endfunction

	function automatic logic [DAY_W-1:0] last_day(
		input logic [MONTH_W-1:0] m,
		input logic               leap
	);
		logic [DAY_W-1:0] len;
		case (m)
			4'd2:                         len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:      len = 5'd30;
			default:                      len = 5'd31;
		endcase
		return len;
	endfunction

	// one restoring step of the remainder; a zero divisor passes the bits through
	function automatic logic [DIST_W-1:0] rem_step(
		input logic [DIST_W-1:0] r,
		input logic              b,
		input logic [CNT_W-1:0]  p
	);
		logic [DIST_W-1:0] t;
		logic [DIST_W-1:0] pe;
		t  = {r[DIST_W-2:0], b};
		pe = {{(DIST_W-CNT_W){1'b0}}, p};
		return (t >= pe) ? t - pe : t;
	endfunction

endpackage
`default_nettype wire

>>> src/date_window_condition.sv
`default_nettype none
// ----------------------------------------------------------------------------
// date_window_condition
// Checks one calendar date per transaction against a day/month window and a
// fixed-day or every-n-days schedule.
// ----------------------------------------------------------------------------
// Usage:
//   Dates enter on date_valid/date_stall with time_valid, year, month, day and
//   day_of_year; a transaction completes on an edge with valid high and stall
//   low. Each date yields exactly one condition_met on result_valid/
//   result_stall, in order.
//   The schedule registers are written through cfg_write/cfg_index/cfg_data
//   while no date is in flight.
//   Throughput is one date per cycle while result_stall stays low. The
//   pipeline has nine stages: year reduction, edge days, window check,
//   five remainder stages of two bits each, and the output register.
//   Reset empties the pipeline and loads the registers with their defaults
//   (window January 1 to January 1, period and run 1, period mode).
//   While result_stall holds, the result stays put and the stages behind it
//   keep filling; date_stall rises once the first stage cannot move.
// ----------------------------------------------------------------------------
module date_window_condition (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [dwc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [dwc_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        date_valid,
	output logic                        date_stall,
	input  logic                        time_valid,
	input  logic [dwc_pkg::YEAR_W-1:0]  year,
	input  logic [dwc_pkg::MONTH_W-1:0] month,
	input  logic [dwc_pkg::DAY_W-1:0]   day,
	input  logic [dwc_pkg::YDAY_W-1:0]  day_of_year,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        condition_met
);

	logic [dwc_pkg::DAY_W-1:0]   start_day_q, end_day_q;
	logic [dwc_pkg::MONTH_W-1:0] start_month_q, end_month_q;
	logic [dwc_pkg::CNT_W-1:0]   period_days_q, run_days_q;
	logic [dwc_pkg::SEL_W-1:0]   month_day_select_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_day_q        <= 5'd1;
			start_month_q      <= 4'd1;
			end_day_q          <= 5'd1;
			end_month_q        <= 4'd1;
			period_days_q      <= 9'd1;
			run_days_q         <= 9'd1;
			month_day_select_q <= 6'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				dwc_pkg::REG_START_DAY:        start_day_q        <= cfg_data[4:0];
				dwc_pkg::REG_START_MONTH:      start_month_q      <= cfg_data[3:0];
				dwc_pkg::REG_END_DAY:          end_day_q          <= cfg_data[4:0];
				dwc_pkg::REG_END_MONTH:        end_month_q        <= cfg_data[3:0];
				dwc_pkg::REG_PERIOD_DAYS:      period_days_q      <= cfg_data;
				dwc_pkg::REG_RUN_DAYS:         run_days_q         <= cfg_data;
				dwc_pkg::REG_MONTH_DAY_SELECT: month_day_select_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	logic valid_s1, valid_s2, valid_s3, valid_s9;
	logic adv_s1, adv_s2, adv_s3, adv_s9;
	logic rem_stall, rem_valid;
	logic [dwc_pkg::DIST_W-1:0] rem_out;
	dwc_pkg::dwc_side_t rem_side;

	assign adv_s9 = !valid_s9 || !result_stall;
	assign adv_s3 = !valid_s3 || !rem_stall;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign date_stall    = !adv_s1;
	assign result_valid  = valid_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= date_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s9) valid_s9 <= rem_valid;
		end
	end

	// stage 1: reduce year and previous year for the divisibility test
	logic [dwc_pkg::YEAR_W-1:0]  prev_c;
	logic                        tv_s1;
	logic [dwc_pkg::MONTH_W-1:0] month_s1;
	logic [dwc_pkg::DAY_W-1:0]   day_s1;
	logic [dwc_pkg::YDAY_W-1:0]  yday_s1;
	logic [3:0]                  year_lo_s1, prev_lo_s1;
	logic [dwc_pkg::YEAR_W-1:0]  mul_y_s1, mul_p_s1;

	assign prev_c = year - 12'd1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			tv_s1      <= time_valid;
			month_s1   <= month;
			day_s1     <= day;
			yday_s1    <= day_of_year;
			year_lo_s1 <= year[3:0];
			prev_lo_s1 <= prev_c[3:0];
			mul_y_s1   <= 12'(year * dwc_pkg::DIV25_INV);
			mul_p_s1   <= 12'(prev_c * dwc_pkg::DIV25_INV);
		end
	end

	// stage 2: leap flags and window edge days
	logic leap_y_c, leap_p_c;
	logic signed [dwc_pkg::WDAY_W-1:0] ys_c, ye_c, sp_c;
	logic                        tv_s2, leap_y_s2, leap_p_s2;
	logic [dwc_pkg::MONTH_W-1:0] month_s2;
	logic [dwc_pkg::DAY_W-1:0]   day_s2;
	logic [dwc_pkg::YDAY_W-1:0]  yday_s2;
	logic signed [dwc_pkg::WDAY_W-1:0] ys_s2, ye_s2, sd_s2;

	assign leap_y_c = (year_lo_s1[1:0] == 2'd0)
		&& ((mul_y_s1 > dwc_pkg::DIV25_MAX) || (year_lo_s1 == 4'd0));
	assign leap_p_c = (prev_lo_s1[1:0] == 2'd0)
		&& ((mul_p_s1 > dwc_pkg::DIV25_MAX) || (prev_lo_s1 == 4'd0));
	assign ys_c = dwc_pkg::win_day(start_month_q, start_day_q, leap_y_c);
	assign ye_c = dwc_pkg::win_day(end_month_q, end_day_q, leap_y_c);
	assign sp_c = dwc_pkg::win_day(start_month_q, start_day_q, leap_p_c);

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			tv_s2     <= tv_s1;
			month_s2  <= month_s1;
			day_s2    <= day_s1;
			yday_s2   <= yday_s1;
			leap_y_s2 <= leap_y_c;
			leap_p_s2 <= leap_p_c;
			ys_s2     <= ys_c;
			ye_s2     <= ye_c;
			sd_s2     <= (start_month_q > month_s1) ? sp_c : ys_c;
		end
	end

	// stage 3: window test, fixed-day match and distance from window start
	logic signed [dwc_pkg::WDAY_W-1:0] yday_sg, dist_c, dist_adj;
	logic                        win_c, day_hit_c, sel_zero;
	logic [dwc_pkg::SEL_W-1:0]   target_c;
	logic                        tv_s3;
	dwc_pkg::dwc_side_t          side_c, side_s3;
	logic [dwc_pkg::DIST_W-1:0]  delta_s3;

	assign yday_sg = $signed({2'b00, yday_s2});

	always_comb begin
		if (ys_s2 <= ye_s2) begin
			win_c = ((month_s2 > start_month_q) && (month_s2 < end_month_q))
				|| (((month_s2 == start_month_q) || (month_s2 == end_month_q))
				&& (yday_sg >= ys_s2) && (yday_sg <= ye_s2));
		end else begin
			win_c = (month_s2 > start_month_q) || (month_s2 < end_month_q)
				|| ((month_s2 == start_month_q) && (yday_sg >= ys_s2))
				|| ((month_s2 == end_month_q) && (yday_sg <= ye_s2));
		end
	end

	assign target_c  = (month_day_select_q == dwc_pkg::SEL_LAST_DAY)
		? {1'b0, dwc_pkg::last_day(month_s2, leap_y_s2)} : month_day_select_q;
	assign day_hit_c = ({1'b0, day_s2} == target_c);
	assign sel_zero  = (month_day_select_q == dwc_pkg::SEL_PERIOD);

	assign dist_c   = yday_sg - sd_s2;
	assign dist_adj = dist_c[dwc_pkg::WDAY_W-1]
		? dist_c + (leap_p_s2 ? 11'sd366 : 11'sd365) : dist_c;

	assign side_c.use_rem    = tv_s2 && win_c && sel_zero && !dist_adj[dwc_pkg::WDAY_W-1];
	assign side_c.direct_met = tv_s2 && win_c && !sel_zero && day_hit_c;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			tv_s3    <= tv_s2;
			side_s3  <= side_c;
			delta_s3 <= dist_adj[dwc_pkg::DIST_W-1:0];
		end
	end

	dwc_rem u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.period    (period_days_q),
		.in_valid  (valid_s3),
		.in_stall  (rem_stall),
		.in_delta  (delta_s3),
		.in_side   (side_s3),
		.out_valid (rem_valid),
		.out_stall (!adv_s9),
		.out_rem   (rem_out),
		.out_side  (rem_side)
	);

	// output register
	logic met_s9;

	always_ff @(posedge clk) begin
		if (adv_s9) begin
			met_s9 <= rem_side.use_rem
				? (rem_out < {1'b0, run_days_q}) : rem_side.direct_met;
		end
	end

	assign condition_met = met_s9;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		date_stall |-> valid_s1)
		else $error("date channel stalls with an empty first stage");

	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> !(side_s3.use_rem && side_s3.direct_met))
		else $error("period and fixed-day results both selected");

	a_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !tv_s3 |-> (!side_s3.use_rem && !side_s3.direct_met))
		else $error("date without valid time can still match");

endmodule
`default_nettype wire

>>> src/dwc_rem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwc_rem
// Five-stage remainder pipeline: two restoring steps per stage, side flags
// carried along with the data, one transaction per cycle when not stalled.
// ----------------------------------------------------------------------------
module dwc_rem (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [dwc_pkg::CNT_W-1:0]  period,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [dwc_pkg::DIST_W-1:0] in_delta,
	input  dwc_pkg::dwc_side_t         in_side,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [dwc_pkg::DIST_W-1:0] out_rem,
	output dwc_pkg::dwc_side_t         out_side
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	logic [dwc_pkg::DIST_W-1:0] dvd_s1, dvd_s2, dvd_s3, dvd_s4;
	logic [dwc_pkg::DIST_W-1:0] rem_s1, rem_s2, rem_s3, rem_s4, rem_s5;
	dwc_pkg::dwc_side_t side_s1, side_s2, side_s3, side_s4, side_s5;

	assign adv_s5 = !valid_s5 || !out_stall;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign in_stall  = !adv_s1;
	assign out_valid = valid_s5;
	assign out_rem   = rem_s5;
	assign out_side  = side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dvd_s1  <= in_delta;
			side_s1 <= in_side;
			rem_s1  <= dwc_pkg::rem_step(dwc_pkg::rem_step('0, in_delta[9], period),
				in_delta[8], period);
		end
		if (adv_s2) begin
			dvd_s2  <= dvd_s1;
			side_s2 <= side_s1;
			rem_s2  <= dwc_pkg::rem_step(dwc_pkg::rem_step(rem_s1, dvd_s1[7], period),
				dvd_s1[6], period);
		end
		if (adv_s3) begin
			dvd_s3  <= dvd_s2;
			side_s3 <= side_s2;
			rem_s3  <= dwc_pkg::rem_step(dwc_pkg::rem_step(rem_s2, dvd_s2[5], period),
				dvd_s2[4], period);
		end
		if (adv_s4) begin
			dvd_s4  <= dvd_s3;
			side_s4 <= side_s3;
			rem_s4  <= dwc_pkg::rem_step(dwc_pkg::rem_step(rem_s3, dvd_s3[3], period),
				dvd_s3[2], period);
		end
		if (adv_s5) begin
			side_s5 <= side_s4;
			rem_s5  <= dwc_pkg::rem_step(dwc_pkg::rem_step(rem_s4, dvd_s4[1], period),
				dvd_s4[0], period);
		end
	end

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("remainder pipeline stalls with an empty first stage");

	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && valid_s5 && out_stall |=> valid_s4)
		else $error("remainder stage four dropped a transaction under stall");

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Date window condition check against an independent model of the schedule.
// Dates go through a queue-fed driver; a monitor compares every condition_met
// with the oldest prediction. A directed set covers year, month and day
// extremes, wrapped windows, last-day and out-of-range selects, zero period
// and negative distances. Ten phases of random dates follow, each with its
// own schedule and one of four patterns of source gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import dwc_pkg::*;

	typedef struct packed {
		logic               known;
		logic [YEAR_W-1:0]  yr;
		logic [MONTH_W-1:0] mon;
		logic [DAY_W-1:0]   mday;
		logic [YDAY_W-1:0]  yday;
	} date_t;

	typedef struct packed {
		logic [DAY_W-1:0]   start_day;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   end_day;
		logic [MONTH_W-1:0] end_month;
		logic [CNT_W-1:0]   period;
		logic [CNT_W-1:0]   run;
		logic [SEL_W-1:0]   select;
	} sched_t;

	localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_write = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               date_valid = 1'b0;
	logic               date_stall;
	logic               time_valid = 1'b0;
	logic [YEAR_W-1:0]  year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic [DAY_W-1:0]   day = '0;
	logic [YDAY_W-1:0]  day_of_year = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic               condition_met;

	date_t  pending_dates [$];
	logic   predicted_met [$];
	sched_t sched;
	int     send_idle_pct = 0;
	int     recv_stall_pct = 0;
	int     errors = 0;

	date_window_condition u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.date_valid    (date_valid),
		.date_stall    (date_stall),
		.time_valid    (time_valid),
		.year          (year),
		.month         (month),
		.day           (day),
		.day_of_year   (day_of_year),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.condition_met (condition_met)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit leap_year(input int y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	function automatic int edge_day_of(input int y, input int m, input int d);
		if (m == 2)
			return d + 30;
		if (m < 3)
			return d - 1;
		return d - 1 + (153 * m - 162) / 5 + int'(leap_year(y));
	endfunction

	function automatic int month_length(input int m, input int y);
		if (m < 1 || m > 12)
			return 31;
		return MONTH_LEN[m-1] + int'(m == 2 && leap_year(y));
	endfunction

	function automatic logic schedule_holds(input sched_t s, input date_t t);
		int  y, prev, mo, yd, sm, em, ys, ye, sd, span, target;
		bit  inside_win;
		y    = int'(t.yr);
		prev = (y == 0) ? 4095 : y - 1;
		mo   = int'(t.mon);
		yd   = int'(t.yday);
		sm   = int'(s.start_month);
		em   = int'(s.end_month);
		if (!t.known)
			return 1'b0;
		ys = edge_day_of(y, sm, int'(s.start_day));
		ye = edge_day_of(y, em, int'(s.end_day));
		if (ys <= ye) begin
			inside_win = (mo > sm && mo < em)
				|| ((mo == sm || mo == em) && yd >= ys && yd <= ye);
		end else begin
			inside_win = mo > sm || mo < em || (mo == sm && yd >= ys)
				|| (mo == em && yd <= ye);
		end
		if (!inside_win)
			return 1'b0;
		if (s.select != SEL_PERIOD) begin
			target = (s.select == SEL_LAST_DAY) ? month_length(mo, y) : int'(s.select);
			return int'(t.mday) == target;
		end
		sd   = edge_day_of((sm > mo) ? prev : y, sm, int'(s.start_day));
		span = yd - sd;
		if (span < 0)
			span += leap_year(prev) ? 366 : 365;
		if (span < 0)
			return 1'b0;
		if (s.period != 0)
			span = span % int'(s.period);
		return span < int'(s.run);
	endfunction

	function automatic date_t mk_date(input bit tv, input int y, input int m, input int d,
		input int yd);
		date_t t;
		t.known = tv;
		t.yr    = YEAR_W'(y);
		t.mon   = MONTH_W'(m);
		t.mday  = DAY_W'(d);
		t.yday  = YDAY_W'(yd);
		return t;
	endfunction

	function automatic date_t on_day(input int y, input int m, input int d);
		return mk_date(1'b1, y, m, d, edge_day_of(y, m, d));
	endfunction

	function automatic sched_t mk_sched(input int sd, input int sm, input int ed, input int em,
		input int per, input int run, input int sel);
		sched_t s;
		s.start_day   = DAY_W'(sd);
		s.start_month = MONTH_W'(sm);
		s.end_day     = DAY_W'(ed);
		s.end_month   = MONTH_W'(em);
		s.period      = CNT_W'(per);
		s.run         = CNT_W'(run);
		s.select      = SEL_W'(sel);
		return s;
	endfunction

	function automatic int pick(input int lo, input int hi, input int w);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return lo;
		if (r < 30)
			return hi;
		if (r < 90)
			return $urandom_range(lo, hi);
		return $urandom_range(0, (1 << w) - 1);
	endfunction

	function automatic sched_t random_sched();
		int r, sel;
		r = $urandom_range(0, 99);
		if (r < 45)
			sel = SEL_PERIOD;
		else if (r < 70)
			sel = $urandom_range(1, 31);
		else if (r < 85)
			sel = SEL_LAST_DAY;
		else
			sel = $urandom_range(33, 63);
		return mk_sched(pick(1, 31, DAY_W), pick(1, 12, MONTH_W), pick(1, 31, DAY_W),
			pick(1, 12, MONTH_W), pick(1, 365, CNT_W), pick(1, 365, CNT_W), sel);
	endfunction

	function automatic date_t random_date();
		int y, m;
		if ($urandom_range(0, 99) < 8)
			return date_t'($urandom);
		case ($urandom_range(0, 9))
			0:       y = 0;
			1:       y = 4095;
			2:       y = 1600 + 100 * $urandom_range(0, 8);
			default: y = $urandom_range(0, 4095);
		endcase
		m = $urandom_range(1, 12);
		random_date = on_day(y, m, $urandom_range(1, month_length(m, y)));
		random_date.known = ($urandom_range(0, 19) != 0);
	endfunction

	task automatic write_reg(input dwc_reg_t idx, input int unsigned val, input int w);
		logic [CFG_W-1:0] d;
		d = CFG_W'($urandom);
		for (int b = 0; b < w; b++)
			d[b] = val[b];
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (pending_dates.size() != 0 || date_valid || predicted_met.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic phase_start(input sched_t s, input int mode);
		drain();
		write_reg(REG_START_DAY, s.start_day, DAY_W);
		write_reg(REG_START_MONTH, s.start_month, MONTH_W);
		write_reg(REG_END_DAY, s.end_day, DAY_W);
		write_reg(REG_END_MONTH, s.end_month, MONTH_W);
		write_reg(REG_PERIOD_DAYS, s.period, CNT_W);
		write_reg(REG_RUN_DAYS, s.run, CNT_W);
		write_reg(REG_MONTH_DAY_SELECT, s.select, SEL_W);
		sched = s;
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	// advance to the next date once the current transaction is taken
	always @(posedge clk) begin
		if (date_valid && !date_stall)
			predicted_met.push_back(schedule_holds(sched,
				date_t'({time_valid, year, month, day, day_of_year})));
		if (!date_valid || !date_stall) begin
			if (pending_dates.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				date_valid <= 1'b1;
				{time_valid, year, month, day, day_of_year} <= pending_dates.pop_front();
			end else begin
				date_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		logic want;
		if (result_valid && !result_stall) begin
			if (predicted_met.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0b",
					$time, condition_met);
			end else begin
				want = predicted_met.pop_front();
				if (condition_met !== want) begin
					errors++;
					$display("%0t: condition_met mismatch, expected %0b, actual %0b",
						$time, want, condition_met);
				end
			end
		end
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		sched = mk_sched(1, 1, 1, 1, 1, 1, SEL_PERIOD);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset schedule: window is January 1 only
		pending_dates.push_back(mk_date(1'b0, 2024, 1, 1, 0));
		pending_dates.push_back(on_day(0, 1, 1));
		pending_dates.push_back(on_day(2000, 1, 1));
		pending_dates.push_back(on_day(4095, 12, 31));
		pending_dates.push_back(mk_date(1'b1, 4095, 15, 31, 511));
		pending_dates.push_back(mk_date(1'b1, 0, 0, 0, 0));

		phase_start(mk_sched(15, 11, 10, 2, 1, 1, SEL_LAST_DAY), 0);
		pending_dates.push_back(on_day(2023, 2, 28));
		pending_dates.push_back(on_day(2024, 2, 29));
		pending_dates.push_back(on_day(2024, 2, 28));
		pending_dates.push_back(on_day(1900, 2, 28));
		pending_dates.push_back(on_day(1900, 1, 31));
		pending_dates.push_back(on_day(2100, 12, 31));
		pending_dates.push_back(on_day(2000, 11, 30));
		pending_dates.push_back(mk_date(1'b1, 2023, 0, 31, 0));
		pending_dates.push_back(mk_date(1'b1, 2023, 13, 31, 400));

		phase_start(mk_sched(1, 1, 31, 12, 7, 3, 45), 0);
		pending_dates.push_back(on_day(2023, 3, 31));
		pending_dates.push_back(on_day(2023, 5, 15));

		phase_start(mk_sched(0, 12, 1, 3, 0, 365, SEL_PERIOD), 0);
		pending_dates.push_back(on_day(0, 1, 5));
		pending_dates.push_back(on_day(2001, 1, 5));
		pending_dates.push_back(on_day(2023, 12, 3));

		phase_start(mk_sched(31, 15, 1, 3, 30, 200, SEL_PERIOD), 0);
		pending_dates.push_back(on_day(2000, 1, 11));
		pending_dates.push_back(on_day(2023, 2, 20));

		for (int p = 0; p < 10; p++) begin
			case (p)
				0: phase_start(mk_sched(1, 1, 31, 12, 365, 1, SEL_PERIOD), p % 4);
				1: phase_start(mk_sched(31, 12, 1, 1, 1, 365, SEL_PERIOD), p % 4);
				2: phase_start(mk_sched(31, 12, 31, 12, 365, 365, SEL_LAST_DAY), p % 4);
				default: phase_start(random_sched(), p % 4);
			endcase
			repeat (80) pending_dates.push_back(random_date());
		end

		drain();
		if (errors == 0 && predicted_met.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
